// ===== rtl/core/hfdq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfdq_pkg
// shared types and codes for the header/footer deframer with frame queue
// ----------------------------------------------------------------------------
package hfdq_pkg;

    // input opcodes, carried on the input tuser
    localparam logic OP_FEED    = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    // result kinds, carried on the output tuser
    localparam logic KIND_STATUS  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // configuration register indexes
    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_HEADER = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FOOTER = 8'd1;

    localparam logic [7:0] HEADER_RESET = 8'd170;
    localparam logic [7:0] FOOTER_RESET = 8'd85;

    // command queue between front and back
    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_AW    = 2;

    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic       opcode;
        logic [7:0] rx_byte;
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        logic [CFG_INDEX_W-1:0] index;
        logic [7:0]             data;
    } cfg_wr_t;

endpackage

// ===== rtl/core/header_footer_deframer_with_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_footer_deframer_with_queue
// byte-stream deframer with a circular queue of received frames
// ----------------------------------------------------------------------------
// Each input item either feeds one received byte to the frame parser
// (tuser 0) or asks for the oldest queued frame (tuser 1). The parser hunts
// for the header byte, captures PAYLOAD_BYTES payload bytes straight into the
// frame store, then checks the footer byte; a good footer commits the frame
// to a queue of QUEUE_FRAMES frames. A stray byte while hunting, a wrong
// footer or a full queue at the footer bumps a saturating 16-bit error count.
// A feed gives one status item; an extract gives PAYLOAD_BYTES items, one
// payload byte each (zeros with payload_valid low if the queue was empty),
// with tlast on the final one. Items enter a small command queue through an
// input register, so the input keeps accepting while results wait. A feed is
// handled as soon as it is popped; an extract holds the back end while the
// single read port of the frame store starts the read and then gives one
// byte a cycle while the output is free. The frame store holds QUEUE_FRAMES
// + 1 slots so that capture never touches a queued frame; its contents are
// undefined after reset and need no clearing. Header and footer values are
// written on the cfg port (index 0 header, 1 footer), which is always ready.
// ----------------------------------------------------------------------------
module header_footer_deframer_with_queue
#(
    parameter int PAYLOAD_BYTES = 16,
    parameter int QUEUE_FRAMES  = 8
)
(
    input  logic                                   clk,
    input  logic                                   rst_n,

    // input items
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [7:0]                             s_tdata,   // rx_byte
    input  logic [0:0]                             s_tuser,   // opcode

    // result items
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // parser_state[1:0], payload_byte[9:2], payload_valid[10],
    // frame_available[11], frames_queued[15:12], error_total[31:16]
    output logic [hfdq_pkg::OUT_DATA_W-1:0]        m_tdata,
    output logic [0:0]                             m_tuser,   // result_kind
    output logic                                   m_tlast,   // last_byte

    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [hfdq_pkg::CFG_INDEX_W-1:0]       cfg_index,
    input  logic [7:0]                             cfg_data
);
    import hfdq_pkg::*;

    logic    push;
    cmd_t    push_cmd;
    logic    q_full;
    logic    cmd_valid;
    cmd_t    cmd;
    logic    cmd_pop;
    cfg_wr_t cfg_wr;

    // register writes are taken every cycle
    assign cfg_ready    = 1'b1;
    assign cfg_wr.valid = cfg_valid;
    assign cfg_wr.index = cfg_index;
    assign cfg_wr.data  = cfg_data;

    // front: input register and opcode classification
    hfdq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    // short command queue so each side stalls on its own
    hfdq_cmdq u_cmdq
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (cmd_pop),
        .cmd_valid (cmd_valid),
        .cmd       (cmd)
    );

    // back: parser, frame store and result sequencing
    hfdq_back
    #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .QUEUE_FRAMES  (QUEUE_FRAMES)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_wr),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

// ===== rtl/core/hfdq_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfdq_front
// input stage: accepts items and turns them into queued commands
// ----------------------------------------------------------------------------
module hfdq_front
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [7:0]    s_tdata,   // rx_byte
    input  logic [0:0]    s_tuser,   // opcode
    output logic          push,
    output hfdq_pkg::cmd_t push_cmd,
    input  logic          q_full
);
    import hfdq_pkg::*;

    logic front_valid_reg;
    logic front_valid_next;
    cmd_t front_cmd_reg;
    cmd_t front_cmd_next;
    logic accept;

    assign push     = front_valid_reg && !q_full;
    assign s_tready = !front_valid_reg || !q_full;
    assign accept   = s_tvalid && s_tready;
    assign push_cmd = front_cmd_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        front_cmd_next   = front_cmd_reg;
        if (accept)
        begin
            front_valid_next       = 1'b1;
            front_cmd_next.opcode  = (s_tuser[0] == OP_EXTRACT) ? OP_EXTRACT : OP_FEED;
            // byte is meaningless for an extract, keep it clean
            front_cmd_next.rx_byte = (s_tuser[0] == OP_EXTRACT) ? 8'd0 : s_tdata;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
            front_cmd_reg   <= '0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
            front_cmd_reg   <= front_cmd_next;
        end
    end

endmodule

// ===== rtl/core/hfdq_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfdq_cmdq
// short command queue decoupling the front from the back
// ----------------------------------------------------------------------------
module hfdq_cmdq
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  hfdq_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           cmd_valid,
    output hfdq_pkg::cmd_t cmd
);
    import hfdq_pkg::*;

    localparam int CW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(CMDQ_DEPTH);

    cmd_t                entry_reg [CMDQ_DEPTH];
    logic [CMDQ_AW-1:0]  wr_ptr_reg;
    logic [CMDQ_AW-1:0]  wr_ptr_next;
    logic [CMDQ_AW-1:0]  rd_ptr_reg;
    logic [CMDQ_AW-1:0]  rd_ptr_next;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    logic                do_push;
    logic                do_pop;

    assign full      = (count_reg == DEPTH_C);
    assign cmd_valid = (count_reg != '0);
    assign cmd       = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== rtl/core/hfdq_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hfdq_back
// frame parser, frame store and result sequencer
// ----------------------------------------------------------------------------
module hfdq_back
#(
    parameter int PAYLOAD_BYTES = 16,
    parameter int QUEUE_FRAMES  = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  hfdq_pkg::cfg_wr_t                     cfg,
    input  logic                                  cmd_valid,
    input  hfdq_pkg::cmd_t                        cmd,
    output logic                                  cmd_pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [hfdq_pkg::OUT_DATA_W-1:0]       m_tdata,
    output logic [0:0]                            m_tuser,
    output logic                                  m_tlast
);
    import hfdq_pkg::*;

    // byte index within a frame, capture counter, slot index (one spare slot)
    localparam int IW = (PAYLOAD_BYTES > 1) ? $clog2(PAYLOAD_BYTES) : 1;
    localparam int CW = $clog2(PAYLOAD_BYTES + 1);
    localparam int SW = $clog2(QUEUE_FRAMES + 1);
    localparam int AW = SW + IW;
    localparam int MEM_DEPTH = (QUEUE_FRAMES + 1) * (2 ** IW);

    localparam logic [CW-1:0] PAYLOAD_C = CW'(PAYLOAD_BYTES);
    localparam logic [IW-1:0] K_LAST    = IW'(PAYLOAD_BYTES - 1);
    localparam logic [SW-1:0] QUEUE_C   = SW'(QUEUE_FRAMES);
    localparam logic [SW:0]   SLOTS_C   = (SW + 1)'(QUEUE_FRAMES + 1);

    typedef enum logic [1:0] {
        H_WAIT_HEADER = 2'd0,
        H_READING     = 2'd1,
        H_WAIT_FOOTER = 2'd2,
        H_READY       = 2'd3
    } hunt_t;

    typedef enum logic {
        B_IDLE,
        B_EMIT
    } bstate_t;

    logic [7:0] mem [MEM_DEPTH];

    bstate_t              bstate_reg, bstate_next;
    hunt_t                hunt_reg, hunt_next, hunt_tmp;
    logic [CW-1:0]        idx_reg, idx_next, idx_inc;
    logic [SW-1:0]        head_reg, head_next;
    logic [SW-1:0]        fill_reg, fill_next;
    logic [15:0]          err_reg, err_next;
    logic [7:0]           header_reg, header_next;
    logic [7:0]           footer_reg, footer_next;
    logic [IW-1:0]        k_reg, k_next;
    logic [SW-1:0]        rd_slot_reg, rd_slot_next;
    logic                 emit_valid_reg, emit_valid_next;
    logic                 out_valid_reg, out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic                 out_user_reg, out_user_next;
    logic                 out_last_reg, out_last_next;
    logic [7:0]           mem_q;

    logic                 out_free;
    logic                 out_load;
    logic                 err_inc;
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [SW:0]          tail_sum;
    logic [SW-1:0]        tail_slot;
    logic [7:0]           res_byte;
    logic                 res_valid;

    assign out_free = !out_valid_reg || m_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;
    assign m_tlast  = out_last_reg;

    // free slot after the queued frames; extracts do not move it
    assign tail_sum  = {1'b0, head_reg} + {1'b0, fill_reg};
    assign tail_slot = (tail_sum >= SLOTS_C) ? SW'(tail_sum - SLOTS_C) : SW'(tail_sum);
    assign idx_inc   = idx_reg + CW'(1);

    always_comb
    begin
        bstate_next     = bstate_reg;
        hunt_next       = hunt_reg;
        hunt_tmp        = hunt_reg;
        idx_next        = idx_reg;
        head_next       = head_reg;
        fill_next       = fill_reg;
        header_next     = header_reg;
        footer_next     = footer_reg;
        k_next          = k_reg;
        rd_slot_next    = rd_slot_reg;
        emit_valid_next = emit_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        out_user_next   = out_user_reg;
        out_last_next   = out_last_reg;
        cmd_pop         = 1'b0;
        out_load        = 1'b0;
        err_inc         = 1'b0;
        mem_we          = 1'b0;
        mem_wa          = {tail_slot, idx_reg[IW-1:0]};
        rd_en           = 1'b0;
        rd_addr         = {rd_slot_reg, k_reg};
        res_byte        = 8'd0;
        res_valid       = 1'b0;

        if (cfg.valid)
        begin
            if (cfg.index == REG_HEADER)
            begin
                header_next = cfg.data;
            end
            else if (cfg.index == REG_FOOTER)
            begin
                footer_next = cfg.data;
            end
        end

        case (bstate_reg)
            B_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_pop = 1'b1;
                    if (cmd.opcode == OP_FEED)
                    begin
                        // ready falls back to hunting before the byte is looked at
                        hunt_tmp  = (hunt_reg == H_READY) ? H_WAIT_HEADER : hunt_reg;
                        hunt_next = hunt_tmp;
                        case (hunt_tmp)
                            H_WAIT_HEADER:
                            begin
                                if (cmd.rx_byte == header_reg)
                                begin
                                    idx_next  = '0;
                                    hunt_next = H_READING;
                                end
                                else
                                begin
                                    err_inc = 1'b1;
                                end
                            end
                            H_READING:
                            begin
                                mem_we   = 1'b1;
                                idx_next = idx_inc;
                                if (idx_inc >= PAYLOAD_C)
                                begin
                                    hunt_next = H_WAIT_FOOTER;
                                end
                            end
                            H_WAIT_FOOTER:
                            begin
                                idx_next = '0;
                                if (cmd.rx_byte == footer_reg)
                                begin
                                    hunt_next = H_READY;
                                    if (fill_reg < QUEUE_C)
                                    begin
                                        fill_next = fill_reg + 1'b1;
                                    end
                                    else
                                    begin
                                        err_inc = 1'b1;
                                    end
                                end
                                else
                                begin
                                    err_inc   = 1'b1;
                                    hunt_next = H_WAIT_HEADER;
                                end
                            end
                            default:
                            begin
                                hunt_next = H_WAIT_HEADER;
                            end
                        endcase
                        out_load      = 1'b1;
                        out_user_next = KIND_STATUS;
                        out_last_next = 1'b1;
                    end
                    else
                    begin
                        emit_valid_next = (fill_reg != '0);
                        rd_slot_next    = head_reg;
                        k_next          = '0;
                        rd_en           = 1'b1;
                        rd_addr         = {head_reg, {IW{1'b0}}};
                        if (fill_reg != '0)
                        begin
                            head_next = (head_reg == QUEUE_C) ? '0 : head_reg + 1'b1;
                            fill_next = fill_reg - 1'b1;
                        end
                        if (hunt_reg == H_READY && fill_next == '0)
                        begin
                            hunt_next = H_WAIT_HEADER;
                        end
                        bstate_next = B_EMIT;
                    end
                end
            end
            B_EMIT:
            begin
                if (out_free)
                begin
                    out_load      = 1'b1;
                    out_user_next = KIND_PAYLOAD;
                    out_last_next = (k_reg == K_LAST);
                    res_byte      = emit_valid_reg ? mem_q : 8'd0;
                    res_valid     = emit_valid_reg;
                    if (k_reg == K_LAST)
                    begin
                        bstate_next = B_IDLE;
                    end
                    else
                    begin
                        k_next  = k_reg + 1'b1;
                        rd_en   = 1'b1;
                        rd_addr = {rd_slot_reg, k_next};
                    end
                end
            end
            default:
            begin
                bstate_next = B_IDLE;
            end
        endcase

        err_next = (err_inc && err_reg != 16'hFFFF) ? err_reg + 16'd1 : err_reg;

        if (out_load)
        begin
            out_valid_next = 1'b1;
            out_data_next  = {err_next, 4'(fill_next), (fill_next != '0), res_valid,
                              res_byte, 2'(hunt_next)};
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bstate_reg     <= B_IDLE;
            hunt_reg       <= H_WAIT_HEADER;
            idx_reg        <= '0;
            head_reg       <= '0;
            fill_reg       <= '0;
            err_reg        <= '0;
            header_reg     <= HEADER_RESET;
            footer_reg     <= FOOTER_RESET;
            k_reg          <= '0;
            rd_slot_reg    <= '0;
            emit_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
            out_user_reg   <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            bstate_reg     <= bstate_next;
            hunt_reg       <= hunt_next;
            idx_reg        <= idx_next;
            head_reg       <= head_next;
            fill_reg       <= fill_next;
            err_reg        <= err_next;
            header_reg     <= header_next;
            footer_reg     <= footer_next;
            k_reg          <= k_next;
            rd_slot_reg    <= rd_slot_next;
            emit_valid_reg <= emit_valid_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
            out_user_reg   <= out_user_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= cmd.rx_byte;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= QUEUE_C)
        else $error("frame count above queue size");

    a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= QUEUE_C)
        else $error("queue head outside slot range");

    a_capture_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hunt_reg == H_READING |-> idx_reg < PAYLOAD_C)
        else $error("capture index past payload length");

    a_last_ends_emit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && out_last_next |=> bstate_reg == B_IDLE)
        else $error("sequencer busy after last item");

    a_pop_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> bstate_reg == B_IDLE && out_free)
        else $error("command taken while sequencer busy");

endmodule

// ===== test/header_footer_deframer_with_queue_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// header_footer_deframer_with_queue_test
// self-checking bench for the header/footer deframer with frame queue
// ----------------------------------------------------------------------------
// A directed table covers stray bytes, empty extracts, frames with extreme
// payloads, a byte fed in the ready state, a wrong footer, a wrap of the
// queue and a drop on a full queue. Random phases then send mostly
// well-formed frames with random payloads, mixed with broken and truncated
// frames, noise bytes and extracts, under several header/footer settings.
// A short burst of back-to-back stray bytes and an extract close the run.
// Every result item is checked field by field against a behavioral model
// of the parser and queue kept inside the bench.
// ----------------------------------------------------------------------------
module header_footer_deframer_with_queue_test;

    import hfdq_pkg::*;

    localparam int PAYLOAD_BYTES = 16;
    localparam int QUEUE_FRAMES  = 8;

    // an index past the last register, writes to it must be ignored
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 8'd2;

    // parser states as reported in the status field
    typedef enum logic [1:0]
    {
        HUNT_HEADER  = 2'd0,
        HUNT_PAYLOAD = 2'd1,
        HUNT_FOOTER  = 2'd2,
        HUNT_READY   = 2'd3
    } hunt_t;

    // one result item, unpacked from the output stream
    typedef struct
    {
        logic        kind;
        logic [1:0]  state;
        logic [7:0]  data;
        logic        valid;
        logic        last;
        logic        avail;
        logic [3:0]  queued;
        logic [15:0] errors;
    } deframe_out_t;

    // directed table: a single item, a whole frame, or a frame body + footer
    typedef enum logic [1:0]
    {
        ROW_ITEM  = 2'd0,
        ROW_FRAME = 2'd1,
        ROW_BODY  = 2'd2
    } row_kind_t;

    // chk rows carry the status expected after the row's last item
    typedef struct
    {
        row_kind_t   kind;
        logic        op;
        logic [7:0]  data;     // item byte, or payload seed for frame rows
        logic [7:0]  foot;     // footer byte for frame rows
        logic        chk;
        hunt_t       st;
        logic [3:0]  q;
        logic [15:0] e;
    } row_t;

    localparam int PLAN_ROWS = 22;

    // bodies follow seed + k * 0x11, so seed 0x00 walks 0x00 .. 0xff
    row_t plan [PLAN_ROWS] = '{
        '{ROW_ITEM,  OP_FEED,    8'h00,        8'h00,        1'b1, HUNT_HEADER,  4'd0, 16'd1},
        '{ROW_ITEM,  OP_EXTRACT, 8'h00,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0},
        '{ROW_ITEM,  OP_FEED,    8'hff,        8'h00,        1'b1, HUNT_HEADER,  4'd0, 16'd2},
        '{ROW_FRAME, OP_FEED,    8'h00,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd1, 16'd2},
        '{ROW_ITEM,  OP_FEED,    FOOTER_RESET, 8'h00,        1'b1, HUNT_HEADER,  4'd1, 16'd3},
        '{ROW_ITEM,  OP_FEED,    HEADER_RESET, 8'h00,        1'b1, HUNT_PAYLOAD, 4'd1, 16'd3},
        '{ROW_BODY,  OP_FEED,    8'h5a,        HEADER_RESET, 1'b1, HUNT_HEADER,  4'd1, 16'd4},
        '{ROW_ITEM,  OP_EXTRACT, 8'hff,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0},
        '{ROW_FRAME, OP_FEED,    8'h33,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd1, 16'd4},
        '{ROW_ITEM,  OP_EXTRACT, 8'h00,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0},
        '{ROW_ITEM,  OP_EXTRACT, 8'h00,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0},
        '{ROW_ITEM,  OP_EXTRACT, 8'h00,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0},
        '{ROW_FRAME, OP_FEED,    8'h01,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd1, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h02,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd2, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h03,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd3, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h04,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd4, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h05,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd5, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h06,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd6, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h07,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd7, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h08,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd8, 16'd4},
        '{ROW_FRAME, OP_FEED,    8'h09,        FOOTER_RESET, 1'b1, HUNT_READY,   4'd8, 16'd5},
        '{ROW_ITEM,  OP_EXTRACT, 8'h00,        8'h00,        1'b0, HUNT_HEADER,  4'd0, 16'd0}
    };

    // clock, reset and ports
    logic clk = 1'b0;
    logic rst_n;

    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;    // rx_byte
    logic [0:0]             s_tuser;    // opcode

    logic                   m_tvalid;
    logic                   m_tready;
    // parser_state[1:0], payload_byte[9:2], payload_valid[10],
    // frame_available[11], frames_queued[15:12], error_total[31:16]
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [0:0]             m_tuser;    // result_kind
    logic                   m_tlast;    // last_byte

    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // bench model of the parser and the frame queue
    hunt_t       pred_hunt;
    int unsigned pred_index;
    logic [7:0]  pred_capture [PAYLOAD_BYTES];
    logic [7:0]  pred_store [QUEUE_FRAMES][PAYLOAD_BYTES];
    int unsigned pred_head;
    int unsigned pred_fill;
    logic [15:0] pred_errors;
    logic [7:0]  pred_hdr;
    logic [7:0]  pred_ftr;

    // result items still to arrive, oldest first
    deframe_out_t expected_items [$];

    // run bookkeeping
    int  fails         = 0;
    int  items_sent    = 0;
    int  results_seen  = 0;
    int  extracts_sent = 0;
    int  frames_stored = 0;
    int  frames_dropped = 0;
    int  cfg_writes    = 0;
    bit  quiet         = 1'b0;   // no idling on either side
    bit  tx_busy       = 1'b1;
    bit  rx_busy       = 1'b1;

    header_footer_deframer_with_queue
    #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES),
        .QUEUE_FRAMES  (QUEUE_FRAMES)
    )
    dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // model
    // ------------------------------------------------------------------------

    // status fields always show the state after the item was processed
    function automatic deframe_out_t status_now(logic kind, logic [7:0] data,
                                                logic valid, logic last);
        deframe_out_t r;
        r.kind   = kind;
        r.state  = pred_hunt;
        r.data   = data;
        r.valid  = valid;
        r.last   = last;
        r.avail  = (pred_fill != 0);
        r.queued = 4'(pred_fill);
        r.errors = pred_errors;
        return r;
    endfunction

    // error count sticks at its maximum
    function automatic void count_error();
        if (pred_errors != 16'hffff)
            pred_errors++;
    endfunction

    task automatic predict_deframe(logic op, logic [7:0] b);
        logic [7:0]  frame [PAYLOAD_BYTES];
        logic        from_queue;
        int unsigned tail;
        if (op == OP_FEED)
        begin
            // a feed in ready starts over and treats its byte as a header
            if (pred_hunt == HUNT_READY)
                pred_hunt = HUNT_HEADER;
            case (pred_hunt)
                HUNT_HEADER:
                begin
                    if (b == pred_hdr)
                    begin
                        pred_index = 0;
                        pred_hunt  = HUNT_PAYLOAD;
                    end
                    else
                        count_error();
                end
                HUNT_PAYLOAD:
                begin
                    pred_capture[pred_index] = b;
                    pred_index++;
                    if (pred_index >= PAYLOAD_BYTES)
                        pred_hunt = HUNT_FOOTER;
                end
                default:
                begin
                    if (b == pred_ftr)
                    begin
                        // a full queue drops the frame but still ends in ready
                        if (pred_fill < QUEUE_FRAMES)
                        begin
                            tail = (pred_head + pred_fill) % QUEUE_FRAMES;
                            pred_store[tail] = pred_capture;
                            pred_fill++;
                            frames_stored++;
                        end
                        else
                        begin
                            count_error();
                            frames_dropped++;
                        end
                        pred_hunt = HUNT_READY;
                    end
                    else
                    begin
                        count_error();
                        pred_hunt = HUNT_HEADER;
                    end
                    pred_index = 0;
                end
            endcase
            expected_items.push_back(status_now(KIND_STATUS, 8'h00, 1'b0, 1'b1));
        end
        else
        begin
            from_queue = 1'b0;
            for (int k = 0; k < PAYLOAD_BYTES; k++)
                frame[k] = 8'h00;
            if (pred_fill > 0)
            begin
                frame      = pred_store[pred_head];
                pred_head  = (pred_head + 1) % QUEUE_FRAMES;
                pred_fill--;
                from_queue = 1'b1;
            end
            // emptying the queue while in ready drops back to hunting
            if (pred_hunt == HUNT_READY && pred_fill == 0)
                pred_hunt = HUNT_HEADER;
            for (int k = 0; k < PAYLOAD_BYTES; k++)
                expected_items.push_back(status_now(KIND_PAYLOAD, frame[k], from_queue,
                                                    k == PAYLOAD_BYTES - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // returns at the accepting edge, the next call or a drain takes valid down
    task automatic send_item(logic op, logic [7:0] b);
        int gap;
        if (items_sent % 24 == 0)
            tx_busy = ($urandom_range(0, 2) != 0);
        gap = (quiet || !tx_busy) ? 0 : $urandom_range(0, 12);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = b;
        do @(posedge clk); while (!s_tready);
        predict_deframe(op, b);
        items_sent++;
        if (op == OP_EXTRACT)
            extracts_sent++;
    endtask

    // header, body bytes and footer, each part optional
    task automatic send_frame(bit with_header, int body_len, bit rand_body,
                              logic [7:0] seed, bit with_footer, logic [7:0] foot);
        if (with_header)
            send_item(OP_FEED, pred_hdr);
        for (int k = 0; k < body_len; k++)
            send_item(OP_FEED, rand_body ? 8'($urandom) : 8'(seed + k * 8'h11));
        if (with_footer)
            send_item(OP_FEED, foot);
    endtask

    // stop sending and wait until every result is back and the block is quiet
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_items.size() != 0)
            @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        if (idx == REG_HEADER)
            pred_hdr = val;
        else if (idx == REG_FOOTER)
            pred_ftr = val;
        cfg_writes++;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // mostly good frames with random payloads, plus noise, faults and extracts
    task automatic run_phase(int count, bit drain_mid);
        int stop_at;
        int pick;
        bit drained;
        stop_at = items_sent + count;
        drained = 1'b0;
        while (items_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 50)
                send_frame(1'b1, PAYLOAD_BYTES, 1'b1, 8'h00, 1'b1, pred_ftr);
            else if (pick < 60)
                // wrong footer
                send_frame(1'b1, PAYLOAD_BYTES, 1'b1, 8'h00, 1'b1,
                           pred_ftr ^ 8'($urandom_range(1, 255)));
            else if (pick < 65)
                // truncated, whatever follows lands in the payload
                send_frame(1'b1, $urandom_range(0, PAYLOAD_BYTES - 1), 1'b1, 8'h00,
                           1'b0, 8'h00);
            else if (pick < 85)
                repeat ($urandom_range(1, 3)) send_item(OP_EXTRACT, 8'($urandom));
            else
                send_item(OP_FEED, ($urandom_range(0, 3) == 0) ? pred_hdr
                                                               : 8'($urandom));
            // empty the queue and hold off until all results are in
            if (drain_mid && !drained && items_sent >= stop_at - count / 2)
            begin
                while (pred_fill > 0)
                    send_item(OP_EXTRACT, 8'($urandom));
                send_item(OP_EXTRACT, 8'($urandom));
                wait_drained();
                drained = 1'b1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    function automatic void check_field(string what, int unsigned want,
                                        int unsigned got);
        if (want != got)
        begin
            fails++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, got);
        end
    endfunction

    task automatic check_result();
        deframe_out_t want;
        if (expected_items.size() == 0)
        begin
            fails++;
            $display("%0t ns: result item with none expected, got tdata 0x%0h",
                     $time, m_tdata);
        end
        else
        begin
            want = expected_items.pop_front();
            check_field("result_kind",     want.kind,   m_tuser[0]);
            check_field("parser_state",    want.state,  m_tdata[1:0]);
            check_field("payload_byte",    want.data,   m_tdata[9:2]);
            check_field("payload_valid",   want.valid,  m_tdata[10]);
            check_field("frame_available", want.avail,  m_tdata[11]);
            check_field("frames_queued",   want.queued, m_tdata[15:12]);
            check_field("error_total",     want.errors, m_tdata[31:16]);
            check_field("last_byte",       want.last,   m_tlast);
        end
        results_seen++;
    endtask

    // receiver: stalls drawn per item, in stretches with and without stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        forever
        begin
            if (results_seen % 24 == 0)
                rx_busy = ($urandom_range(0, 2) != 0);
            stall = (quiet || !rx_busy) ? 0 : $urandom_range(0, 12);
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_tready = 1'b1;
            do @(posedge clk); while (!m_tvalid);
            check_result();
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        row_t row;
        deframe_out_t typed;

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        s_tuser   = OP_FEED;
        cfg_valid = 1'b0;
        cfg_index = REG_HEADER;
        cfg_data  = 8'h00;

        // model after reset
        pred_hunt   = HUNT_HEADER;
        pred_index  = 0;
        pred_head   = 0;
        pred_fill   = 0;
        pred_errors = 16'd0;
        pred_hdr    = HEADER_RESET;
        pred_ftr    = FOOTER_RESET;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table, run with the reset header and footer
        for (int i = 0; i < PLAN_ROWS; i++)
        begin
            row = plan[i];
            case (row.kind)
                ROW_ITEM:  send_item(row.op, row.data);
                ROW_FRAME: send_frame(1'b1, PAYLOAD_BYTES, 1'b0, row.data, 1'b1, row.foot);
                default:   send_frame(1'b0, PAYLOAD_BYTES, 1'b0, row.data, 1'b1, row.foot);
            endcase
            // rows with a typed status replace the status of their last item
            if (row.chk)
            begin
                typed.kind   = KIND_STATUS;
                typed.state  = row.st;
                typed.data   = 8'h00;
                typed.valid  = 1'b0;
                typed.last   = 1'b1;
                typed.avail  = (row.q != 0);
                typed.queued = row.q;
                typed.errors = row.e;
                void'(expected_items.pop_back());
                expected_items.push_back(typed);
            end
        end
        wait_drained();

        // random phases under several register settings, extremes first
        write_reg(REG_HEADER, 8'h00);
        write_reg(REG_FOOTER, 8'hff);
        run_phase(6, 1'b0);
        wait_drained();

        write_reg(REG_HEADER, 8'hff);
        write_reg(REG_FOOTER, 8'h00);
        run_phase(6, 1'b1);
        wait_drained();

        // a write past the last register leaves both values alone
        write_reg(REG_UNUSED, 8'($urandom));
        write_reg(REG_HEADER, 8'($urandom));
        write_reg(REG_FOOTER, 8'($urandom));
        run_phase(6, 1'b0);
        wait_drained();

        // header and footer equal
        write_reg(REG_HEADER, 8'h3c);
        write_reg(REG_FOOTER, 8'h3c);
        run_phase(6, 1'b1);
        wait_drained();

        write_reg(REG_HEADER, HEADER_RESET);
        write_reg(REG_FOOTER, FOOTER_RESET);
        run_phase(6, 1'b0);

        // a few stray bytes back to back, then an extract
        quiet = 1'b1;
        repeat (3) send_item(OP_FEED, ~pred_hdr);
        send_item(OP_EXTRACT, 8'h00);
        wait_drained();

        $display("run covered %0d input items (%0d extracts) and %0d result items",
                 items_sent, extracts_sent, results_seen);
        $display("%0d frames queued, %0d dropped on a full queue, %0d register writes",
                 frames_stored, frames_dropped, cfg_writes);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // hard stop well beyond the slowest correct run
    initial
    begin
        #20_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== header_footer_deframer_with_queue.f =====
rtl/core/hfdq_pkg.sv
rtl/core/hfdq_front.sv
rtl/core/hfdq_cmdq.sv
rtl/core/hfdq_back.sv
rtl/core/header_footer_deframer_with_queue.sv
test/header_footer_deframer_with_queue_test.sv
